// ===== rtl/chip8_instruction_execute_core_assert.svh =====
// Assertion macros for the execute core.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef CHIP8_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every rising edge outside reset.
`define C8IE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define C8IE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define C8IE_ASSERT(label, clk, rst_n, prop, msg)
`define C8IE_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/c8ie_pkg.sv =====
package c8ie_pkg;

    // Fault codes reported with each result.
    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_UNKNOWN = 2'd1,
        FAULT_OVER    = 2'd2,
        FAULT_UNDER   = 2'd3
    } t_fault;

    // Opcode groups, taken from the top nibble of the instruction.
    localparam logic [3:0] OP_SYS     = 4'h0;
    localparam logic [3:0] OP_JP      = 4'h1;
    localparam logic [3:0] OP_CALL    = 4'h2;
    localparam logic [3:0] OP_SE_IMM  = 4'h3;
    localparam logic [3:0] OP_SNE_IMM = 4'h4;
    localparam logic [3:0] OP_SE_REG  = 4'h5;
    localparam logic [3:0] OP_LD_IMM  = 4'h6;
    localparam logic [3:0] OP_ADD_IMM = 4'h7;
    localparam logic [3:0] OP_ALU     = 4'h8;
    localparam logic [3:0] OP_SNE_REG = 4'h9;
    localparam logic [3:0] OP_LD_I    = 4'hA;

    // Function codes of the register ALU group.
    localparam logic [3:0] ALU_LD   = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Whole-word system instructions.
    localparam logic [15:0] INSTR_CLS = 16'h00E0;
    localparam logic [15:0] INSTR_RET = 16'h00EE;

    // Register index of the flag register and the program start address.
    localparam logic [3:0]  REG_VF   = 4'hF;
    localparam logic [11:0] PC_RESET = 12'h200;

    // Outcome of executing one instruction.
    typedef struct packed {
        logic [11:0] next_pc;
        logic        halted;
        t_fault      fault;
        logic        vx_write;
        logic [7:0]  vx_value;
        logic        vf_write;
        logic        vf_value;
        logic        i_write;
        logic [11:0] i_value;
        logic        push;
        logic        pop;
        logic [11:0] ret_addr;
    } t_exec;

endpackage

// ===== rtl/c8ie_ram.sv =====
module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; a read of the address
    // being written returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/c8ie_exec.sv =====
module c8ie_exec (
    input  logic [15:0]    i_instruction,
    input  logic [7:0]     i_vx,
    input  logic [7:0]     i_vy,
    input  logic [11:0]    i_pc,
    input  logic [11:0]    i_tos,
    input  logic           i_stack_empty,
    input  logic           i_stack_full,
    input  logic           i_halted,
    output c8ie_pkg::t_exec o_res
);

    import c8ie_pkg::*;

    logic [3:0]  group;
    logic [3:0]  func;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [11:0] pc2;
    logic [11:0] pc4;
    logic [8:0]  sum;
    t_exec       res;

    assign group = i_instruction[15:12];
    assign func  = i_instruction[3:0];
    assign nn    = i_instruction[7:0];
    assign nnn   = i_instruction[11:0];
    assign pc2   = i_pc + 12'd2;
    assign pc4   = i_pc + 12'd4;
    assign sum   = {1'b0, i_vx} + {1'b0, i_vy};

    // Decode and execute; a fault cancels every effect but the halt.
    always_comb begin
        res          = '0;
        res.next_pc  = pc2;
        res.fault    = FAULT_NONE;
        res.i_value  = nnn;
        res.ret_addr = pc2;
        if (i_halted) begin
            res.next_pc = i_pc;
            res.halted  = 1'b1;
        end else begin
            unique case (group)
                OP_SYS: begin
                    if (i_instruction == INSTR_CLS) begin
                        // No display: clearing the screen does nothing.
                    end else if (i_instruction == INSTR_RET) begin
                        if (i_stack_empty) begin
                            res.fault = FAULT_UNDER;
                        end else begin
                            res.pop     = 1'b1;
                            res.next_pc = i_tos;
                        end
                    end else begin
                        res.fault = FAULT_UNKNOWN;
                    end
                end
                OP_JP: begin
                    res.next_pc = nnn;
                end
                OP_CALL: begin
                    if (i_stack_full) begin
                        res.fault = FAULT_OVER;
                    end else begin
                        res.push    = 1'b1;
                        res.next_pc = nnn;
                    end
                end
                OP_SE_IMM: begin
                    if (i_vx == nn) res.next_pc = pc4;
                end
                OP_SNE_IMM: begin
                    if (i_vx != nn) res.next_pc = pc4;
                end
                OP_SE_REG: begin
                    if (i_vx == i_vy) res.next_pc = pc4;
                end
                OP_LD_IMM: begin
                    res.vx_write = 1'b1;
                    res.vx_value = nn;
                end
                OP_ADD_IMM: begin
                    res.vx_write = 1'b1;
                    res.vx_value = i_vx + nn;
                end
                OP_ALU: begin
                    res.vx_write = 1'b1;
                    unique case (func)
                        ALU_LD:  res.vx_value = i_vy;
                        ALU_OR:  res.vx_value = i_vx | i_vy;
                        ALU_AND: res.vx_value = i_vx & i_vy;
                        ALU_XOR: res.vx_value = i_vx ^ i_vy;
                        ALU_ADD: begin
                            res.vx_value = sum[7:0];
                            res.vf_write = 1'b1;
                            res.vf_value = sum[8];
                        end
                        ALU_SUB: begin
                            res.vx_value = i_vx - i_vy;
                            res.vf_write = 1'b1;
                            res.vf_value = (i_vx >= i_vy);
                        end
                        ALU_SHR: begin
                            res.vx_value = {1'b0, i_vx[7:1]};
                            res.vf_write = 1'b1;
                            res.vf_value = i_vx[0];
                        end
                        ALU_SUBN: begin
                            res.vx_value = i_vy - i_vx;
                            res.vf_write = 1'b1;
                            res.vf_value = (i_vy >= i_vx);
                        end
                        ALU_SHL: begin
                            res.vx_value = {i_vx[6:0], 1'b0};
                            res.vf_write = 1'b1;
                            res.vf_value = i_vx[7];
                        end
                        default: begin
                            res.vx_write = 1'b0;
                            res.fault    = FAULT_UNKNOWN;
                        end
                    endcase
                end
                OP_SNE_REG: begin
                    if (i_vx != i_vy) res.next_pc = pc4;
                end
                OP_LD_I: begin
                    res.i_write = 1'b1;
                end
                default: begin
                    res.fault = FAULT_UNKNOWN;
                end
            endcase

            if (res.fault != FAULT_NONE) begin
                res.next_pc  = i_pc;
                res.halted   = 1'b1;
                res.vx_write = 1'b0;
                res.vx_value = '0;
                res.vf_write = 1'b0;
                res.vf_value = 1'b0;
                res.i_write  = 1'b0;
                res.push     = 1'b0;
                res.pop      = 1'b0;
            end
        end
    end

    assign o_res = res;

endmodule

// ===== rtl/chip8_instruction_execute_core.sv =====
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+--------------------------------------
// request   | in        | i_valid / o_stall   | i_instruction
// result    | out       | o_valid / i_stall   | o_next_pc, o_halted, o_fault, o_vx_*,
//           |           |                     | o_vf_*, o_index_value
//
// One request enters per cycle while o_stall is low. The accepting edge loads the
// input register and the register file and stack RAM reads; the execute logic
// then writes the result register and the machine state as the execute stage fires.
// Reset is synchronous and active low; no clearing pass is needed, the register
// file has per-entry valid bits and the stack RAM is only read where written.
// A stalled result holds the execute stage, and the input register then stalls
// the request side; a result register that is being taken does not stall.
`include "chip8_instruction_execute_core_assert.svh"

module chip8_instruction_execute_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_instruction,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_next_pc,
    output logic        o_halted,
    output logic [1:0]  o_fault,
    output logic        o_vx_write,
    output logic [3:0]  o_vx_index,
    output logic [7:0]  o_vx_value,
    output logic        o_vf_write,
    output logic        o_vf_value,
    output logic [11:0] o_index_value
);

    import c8ie_pkg::*;

    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

    // Pipeline control.
    logic        r_in_valid;
    logic [15:0] r_instr;
    logic [15:0] n_instr;
    logic        r_out_valid;
    logic        in_acc;
    logic        exec_fire;

    // Machine state.
    logic [11:0]    r_pc;
    logic [11:0]    r_index;
    logic [7:0]     r_vf;
    logic [15:0]    r_vld;
    logic [SPW-1:0] r_sp;
    logic [SPW-1:0] n_sp;
    logic [11:0]    r_tos;
    logic           r_halt;

    // Result register.
    logic [11:0] r_next_pc;
    logic        r_halted;
    logic [1:0]  r_fault;
    logic        r_vx_write;
    logic [3:0]  r_vx_index;
    logic [7:0]  r_vx_value;
    logic        r_vf_write;
    logic        r_vf_value;

    // Execute stage signals.
    logic [3:0]  x_idx;
    logic [3:0]  y_idx;
    logic [7:0]  rd_x;
    logic [7:0]  rd_y;
    logic [7:0]  val_x;
    logic [7:0]  val_y;
    logic [11:0] stk_rdata;
    logic        rf_we;
    logic        stk_we;
    logic        do_write;
    t_exec       res;

    assign exec_fire = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !exec_fire;
    assign in_acc    = i_valid && !o_stall;
    assign n_instr   = in_acc ? i_instruction : r_instr;

    assign x_idx = r_instr[11:8];
    assign y_idx = r_instr[7:4];

    // Register file: V0..VE in two RAM copies (one per read port), VF in flops.
    assign do_write = exec_fire && !r_halt && (res.fault == FAULT_NONE);
    assign rf_we    = do_write && res.vx_write && (x_idx != REG_VF);

    c8ie_ram #(.WIDTH(8), .DEPTH(16)) u_rf_x (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (x_idx),
        .i_wdata (res.vx_value),
        .i_raddr (n_instr[11:8]),
        .o_rdata (rd_x)
    );

    c8ie_ram #(.WIDTH(8), .DEPTH(16)) u_rf_y (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (x_idx),
        .i_wdata (res.vx_value),
        .i_raddr (n_instr[7:4]),
        .o_rdata (rd_y)
    );

    // An entry never written reads as zero.
    assign val_x = (x_idx == REG_VF) ? r_vf : (r_vld[x_idx] ? rd_x : 8'd0);
    assign val_y = (y_idx == REG_VF) ? r_vf : (r_vld[y_idx] ? rd_y : 8'd0);

    // Return stack: the top entry lives in r_tos, the ones below in RAM.
    // The read port always presents the entry just below the top.
    always_comb begin
        n_sp = r_sp;
        if (do_write && res.push) begin
            n_sp = r_sp + SPW'(1);
        end else if (do_write && res.pop) begin
            n_sp = r_sp - SPW'(1);
        end
    end

    assign stk_we = do_write && res.push && (r_sp != '0);

    c8ie_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (AW'(r_sp - SPW'(1))),
        .i_wdata (r_tos),
        .i_raddr (AW'(n_sp - SPW'(2))),
        .o_rdata (stk_rdata)
    );

    c8ie_exec u_exec (
        .i_instruction (r_instr),
        .i_vx          (val_x),
        .i_vy          (val_y),
        .i_pc          (r_pc),
        .i_tos         (r_tos),
        .i_stack_empty (r_sp == '0),
        .i_stack_full  (r_sp == SP_FULL),
        .i_halted      (r_halt),
        .o_res         (res)
    );

    // Input register and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (exec_fire) begin
                r_in_valid <= 1'b0;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_instr <= n_instr;
    end

    // Machine state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_RESET;
            r_index <= '0;
            r_vf    <= '0;
            r_vld   <= '0;
            r_sp    <= '0;
            r_tos   <= '0;
            r_halt  <= 1'b0;
        end else begin
            if (exec_fire && res.halted) begin
                r_halt <= 1'b1;
            end
            if (do_write) begin
                r_pc <= res.next_pc;
                r_sp <= n_sp;
                if (res.i_write) begin
                    r_index <= res.i_value;
                end
                if (rf_we) begin
                    r_vld[x_idx] <= 1'b1;
                end
                // The flag write wins over a data write to VF.
                if (res.vf_write) begin
                    r_vf <= {7'd0, res.vf_value};
                end else if (res.vx_write && (x_idx == REG_VF)) begin
                    r_vf <= res.vx_value;
                end
                if (res.push) begin
                    r_tos <= res.ret_addr;
                end else if (res.pop) begin
                    r_tos <= stk_rdata;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_next_pc  <= res.next_pc;
            r_halted   <= res.halted;
            r_fault    <= res.fault;
            r_vx_write <= res.vx_write;
            r_vx_index <= res.vx_write ? x_idx : 4'd0;
            r_vx_value <= res.vx_value;
            r_vf_write <= res.vf_write;
            r_vf_value <= res.vf_value;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_next_pc     = r_next_pc;
    assign o_halted      = r_halted;
    assign o_fault       = r_fault;
    assign o_vx_write    = r_vx_write;
    assign o_vx_index    = r_vx_index;
    assign o_vx_value    = r_vx_value;
    assign o_vf_write    = r_vf_write;
    assign o_vf_value    = r_vf_value;
    assign o_index_value = r_index;

    // Once halted, the machine stays halted until reset.
    `C8IE_ASSERT(a_halt_sticky, i_clk, i_rst_n, r_halt |=> r_halt, "halt flag cleared")
    // A reported fault always comes with the halted status.
    `C8IE_ASSERT(a_fault_halts, i_clk, i_rst_n, (o_valid && (o_fault != FAULT_NONE)) |-> o_halted, "fault without halt")
    // A flag write only ever accompanies a register write.
    `C8IE_ASSERT(a_vf_with_vx, i_clk, i_rst_n, (o_valid && o_vf_write) |-> o_vx_write, "flag write alone")
    // A call grows the stack by exactly one entry.
    `C8IE_ASSERT(a_push_count, i_clk, i_rst_n, (do_write && res.push) |=> (r_sp == ($past(r_sp) + SPW'(1))), "stack count slip")
    // The stack count never passes the depth.
    `C8IE_ASSERT(a_sp_bound, i_clk, i_rst_n, r_sp <= SP_FULL, "stack count beyond depth")

endmodule
